// ===== rtl/core/btxm_pkg.sv =====
package btxm_pkg;

  // trie geometry
  localparam int KEY_BITS   = 10;
  localparam int COUNT_BITS = 16;
  localparam int NUM_LEAVES = 1 << KEY_BITS;
  localparam int NODE_DEPTH = NUM_LEAVES - 1;
  localparam int NODE_W     = KEY_BITS + 1;
  localparam int ANS_W      = KEY_BITS + 1;
  localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  // operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_ABSENT = 2'd1;
  localparam logic [1:0] STAT_SAT    = 2'd2;

  typedef struct packed {
    logic [1:0]          mode;
    logic [KEY_BITS-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [ANS_W-1:0] answer;
    logic [1:0]       status;
  } out_word_t;

  // request from the sequencer to the count stores
  typedef struct packed {
    logic                  leaf_we;
    logic [KEY_BITS-1:0]   leaf_waddr;
    logic [COUNT_BITS-1:0] leaf_wdata;
    logic [KEY_BITS-1:0]   leaf_raddr;
    logic                  node_we;
    logic [KEY_BITS-1:0]   node_waddr;
    logic [NODE_W-1:0]     node_wdata;
    logic [KEY_BITS-1:0]   node_raddr;
  } store_req_t;

endpackage

// ===== rtl/core/btxm_store.sv =====
module btxm_store (
  input  logic                            clk,
  input  btxm_pkg::store_req_t            req,
  output logic [btxm_pkg::COUNT_BITS-1:0] leaf_rdata,
  output logic [btxm_pkg::NODE_W-1:0]     node_rdata
);

  logic [btxm_pkg::COUNT_BITS-1:0] leaf_mem [btxm_pkg::NUM_LEAVES];
  logic [btxm_pkg::NODE_W-1:0]     node_mem [btxm_pkg::NODE_DEPTH];

  // leaf multiplicity store, registered read
  always_ff @(posedge clk) begin
    if (req.leaf_we) begin
      leaf_mem[req.leaf_waddr] <= req.leaf_wdata;
    end
    leaf_rdata <= leaf_mem[req.leaf_raddr];
  end

  // prefix distinct count store, registered read
  always_ff @(posedge clk) begin
    if (req.node_we) begin
      node_mem[req.node_waddr] <= req.node_wdata;
    end
    node_rdata <= node_mem[req.node_raddr];
  end

endmodule

// ===== rtl/core/bit_trie_xor_mex_engine.sv =====
// operation: insert or delete reads and rewrites the leaf count, then makes one
// prefix-count update per trie level when a key appears or vanishes; query
// reads the root count and walks the trie unless the set is full; unused mode
// answers with busy staying low; results cannot be stalled; throughput: one
// word at a time, the next taken at the edge ending the strobe; reset:
// synchronous active-low; a clearing pass then zeroes both count stores one entry a cycle with busy high
module bit_trie_xor_mex_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  btxm_pkg::in_word_t   in_data,
  output logic                 out_valid,
  output btxm_pkg::out_word_t  out_data
);

  localparam int K = btxm_pkg::KEY_BITS;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LEAF  = 3'd2;
  localparam logic [2:0] S_ADJ   = 3'd3;
  localparam logic [2:0] S_QROOT = 3'd4;
  localparam logic [2:0] S_QWALK = 3'd5;

  logic [2:0]                      state_r, state_nxt;
  logic [K-1:0]                    clr_r, clr_nxt;
  logic [1:0]                      mode_r, mode_nxt;
  logic [K-1:0]                    key_r, key_nxt;
  logic [K:0]                      heap_r, heap_nxt;
  logic [btxm_pkg::LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [btxm_pkg::ANS_W-1:0]      ans_r, ans_nxt;
  logic                            out_valid_r, out_valid_nxt;
  btxm_pkg::out_word_t             out_data_r, out_data_nxt;
  btxm_pkg::store_req_t            req;
  logic [btxm_pkg::COUNT_BITS-1:0] leaf_rdata;
  logic [btxm_pkg::NODE_W-1:0]     node_rdata;

  btxm_store u_store (
    .clk        (clk),
    .req        (req),
    .leaf_rdata (leaf_rdata),
    .node_rdata (node_rdata)
  );

  // sequencer
  always_comb begin
    logic [btxm_pkg::LVL_W-1:0] sh;
    logic [K:0]                 heap_c;
    logic [K:0]                 heap_f;
    logic [btxm_pkg::ANS_W-1:0] ans_f;
    logic                       last;
    logic                       full;

    sh     = btxm_pkg::LVL_W'(K - 1) - lvl_r;
    last   = (lvl_r == btxm_pkg::LVL_W'(K - 1));
    heap_c = '0;
    heap_f = heap_r;
    ans_f  = ans_r;
    full   = 1'b0;

    state_nxt     = state_r;
    clr_nxt       = clr_r;
    mode_nxt      = mode_r;
    key_nxt       = key_r;
    heap_nxt      = heap_r;
    lvl_nxt       = lvl_r;
    ans_nxt       = ans_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    req           = '0;

    case (state_r)
      // zero both stores after reset
      S_CLEAR: begin
        req.leaf_we    = 1'b1;
        req.leaf_waddr = clr_r;
        req.node_we    = (clr_r < K'(btxm_pkg::NODE_DEPTH));
        req.node_waddr = clr_r;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      // take a word and issue the first read
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_data.mode;
          key_nxt  = in_data.key;
          heap_nxt = (K+1)'(1);
          lvl_nxt  = '0;
          ans_nxt  = '0;
          case (in_data.mode)
            btxm_pkg::MODE_INSERT, btxm_pkg::MODE_DELETE: begin
              req.leaf_raddr = in_data.key;
              state_nxt      = S_LEAF;
            end
            btxm_pkg::MODE_QUERY: begin
              req.node_raddr = '0;
              state_nxt      = S_QROOT;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{answer: '0, status: btxm_pkg::STAT_OK};
            end
          endcase
        end
      end

      // leaf count known: update it, maybe walk the path
      S_LEAF: begin
        req.leaf_waddr = key_r;
        req.node_raddr = '0;
        heap_nxt       = (K+1)'(1);
        lvl_nxt        = '0;
        out_data_nxt   = '{answer: '0, status: btxm_pkg::STAT_OK};
        if (mode_r == btxm_pkg::MODE_INSERT) begin
          if (leaf_rdata == '1) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = btxm_pkg::STAT_SAT;
            state_nxt           = S_IDLE;
          end else begin
            req.leaf_we    = 1'b1;
            req.leaf_wdata = leaf_rdata + 1'b1;
            if (leaf_rdata == '0) begin
              state_nxt = S_ADJ;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        end else begin
          if (leaf_rdata == '0) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = btxm_pkg::STAT_ABSENT;
            state_nxt           = S_IDLE;
          end else begin
            req.leaf_we    = 1'b1;
            req.leaf_wdata = leaf_rdata - 1'b1;
            if (leaf_rdata == btxm_pkg::COUNT_BITS'(1)) begin
              state_nxt = S_ADJ;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        end
      end

      // write this level's count while reading the next level
      S_ADJ: begin
        req.node_we    = 1'b1;
        req.node_waddr = heap_r[K-1:0] - 1'b1;
        req.node_wdata = (mode_r == btxm_pkg::MODE_INSERT) ? node_rdata + 1'b1
                                                          : node_rdata - 1'b1;
        if (last) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{answer: '0, status: btxm_pkg::STAT_OK};
          state_nxt     = S_IDLE;
        end else begin
          heap_c         = {heap_r[K-1:0], key_r[sh]};
          req.node_raddr = heap_c[K-1:0] - 1'b1;
          heap_nxt       = heap_c;
          lvl_nxt        = lvl_r + 1'b1;
        end
      end

      // root count: full set or start the walk
      S_QROOT: begin
        if (node_rdata == btxm_pkg::NODE_W'(btxm_pkg::NUM_LEAVES)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{answer: btxm_pkg::ANS_W'(btxm_pkg::NUM_LEAVES),
                            status: btxm_pkg::STAT_OK};
          state_nxt     = S_IDLE;
        end else begin
          heap_c = {heap_r[K-1:0], key_r[K-1]};
          if (K == 1) begin
            req.leaf_raddr = heap_c[K-1:0];
          end else begin
            req.node_raddr = heap_c[K-1:0] - 1'b1;
          end
          heap_nxt  = heap_c;
          lvl_nxt   = '0;
          state_nxt = S_QWALK;
        end
      end

      // one level a cycle: flip away from a full child
      S_QWALK: begin
        full = last ? (leaf_rdata != '0)
                    : (node_rdata == (btxm_pkg::NODE_W'(1) << sh));
        if (full) begin
          heap_f = heap_r ^ (K+1)'(1);
          ans_f  = ans_r | (btxm_pkg::ANS_W'(1) << sh);
        end
        if (last) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{answer: ans_f, status: btxm_pkg::STAT_OK};
          state_nxt     = S_IDLE;
        end else begin
          heap_c = {heap_f[K-1:0], key_r[sh - 1'b1]};
          if (lvl_r == btxm_pkg::LVL_W'(K - 2)) begin
            req.leaf_raddr = heap_c[K-1:0];
          end else begin
            req.node_raddr = heap_c[K-1:0] - 1'b1;
          end
          heap_nxt = heap_c;
          ans_nxt  = ans_f;
          lvl_nxt  = lvl_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working word and result registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    key_r      <= key_nxt;
    heap_r     <= heap_nxt;
    lvl_r      <= lvl_nxt;
    ans_r      <= ans_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result only follows a word taken or in progress
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result strobe without a word in progress");

  // a word leaves busy only with its result, apart from the clearing pass
  a_busy_drop_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && ($past(state_r) != S_CLEAR)) |-> out_valid)
    else $error("busy dropped without a result");

  // an accepted word keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted word lost");

  // a flagged result carries no answer
  a_flag_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != btxm_pkg::STAT_OK)) |-> (out_data.answer == '0))
    else $error("flagged result with non-zero answer");

endmodule
